### src/tas_pkg.sv
package tas_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int VERTEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int WEIGHT_W = 32;
  localparam int LIMIT_W = 7;
  localparam int TALLY_W = 8;
  localparam int REQ_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam logic [LIMIT_W-1:0] RESULT_CAP = LIMIT_W'(64);
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(16);
  localparam logic signed [WEIGHT_W-1:0] NO_EDGE_RESET = 32'sh8000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET    = 3'd0,
    REQ_GET    = 3'd1,
    REQ_NCOUNT = 3'd2,
    REQ_NLIST  = 3'd3,
    REQ_ECOUNT = 3'd4,
    REQ_ELIST  = 3'd5
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_NO_EDGE      = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OSEL_ERR,
    OSEL_SET,
    OSEL_GET,
    OSEL_COUNT,
    OSEL_PEND,
    OSEL_FINAL
  } out_sel_t;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic [VERTEX_W-1:0]        vertex_u;
    logic [VERTEX_W-1:0]        vertex_v;
    logic signed [WEIGHT_W-1:0] weight;
    logic [LIMIT_W-1:0]         out_limit;
  } in_item_t;

  typedef struct packed {
    logic                       status;
    logic                       found;
    logic [VERTEX_W-1:0]        result_u;
    logic [VERTEX_W-1:0]        result_v;
    logic signed [WEIGHT_W-1:0] result_weight;
    logic [TALLY_W-1:0]         tally;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic     load;
    logic     clr_step;
    logic     mem_wr;
    logic     mem_rd;
    logic     cnt_inc;
    logic     pend_load;
    logic     advance;
    logic     push;
    out_sel_t sel;
  } tas_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             range_err;
    logic             walk_done;
    logic             hit;
    logic             pend_valid;
    logic             out_free;
    logic             clr_last;
  } tas_stat_t;

endpackage

### src/tas_datapath.sv
module tas_datapath import tas_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tas_cmd_t               cmd,
  output tas_stat_t              stat,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WEIGHT_W-1:0]    cfg_data,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item
);

  localparam int DEPTH = MAX_VERTICES * (MAX_VERTICES + 1) / 2;
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2 * NW + 1;

  logic [COUNT_W-1:0]         vertex_count;
  logic signed [WEIGHT_W-1:0] no_edge;
  in_item_t                   req;
  logic [LIMIT_W-1:0]         lim;
  logic [NW-1:0]              ia;
  logic [NW-1:0]              ib;
  logic [LIMIT_W-1:0]         k;
  logic [TALLY_W-1:0]         cnt;
  logic                       pend_valid;
  logic [VERTEX_W-1:0]        pend_u;
  logic [VERTEX_W-1:0]        pend_v;
  logic signed [WEIGHT_W-1:0] pend_w;
  logic [AW-1:0]              clr_idx;
  logic signed [WEIGHT_W-1:0] mem [DEPTH];
  logic signed [WEIGHT_W-1:0] rd_data;

  logic [NW-1:0]              n_act;
  logic                       u_big;
  logic                       v_big;
  logic                       is_pair;
  logic                       is_list;
  logic                       is_sg;
  logic [NW-1:0]              op_x;
  logic [NW-1:0]              op_y;
  logic [NW-1:0]              hi;
  logic [NW-1:0]              lo;
  logic [PW-1:0]              tri_prod;
  logic [AW-1:0]              slot;
  logic [AW-1:0]              addr;
  logic                       mem_we;
  logic signed [WEIGHT_W-1:0] wdata;
  logic                       hit;
  logic                       out_free;
  out_item_t                  out_next;

  // vertex count saturates at the store size
  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_act = NW'(MAX_VERTICES);
    end else begin
      n_act = NW'(vertex_count);
    end
  end

  assign u_big = 32'(req.vertex_u) >= 32'(n_act);
  assign v_big = 32'(req.vertex_v) >= 32'(n_act);
  assign is_sg = (req.req_type == REQ_SET) || (req.req_type == REQ_GET);
  assign is_pair = (req.req_type == REQ_ECOUNT) || (req.req_type == REQ_ELIST);
  assign is_list = (req.req_type == REQ_NLIST) || (req.req_type == REQ_ELIST);

  // slot of (x,y) is hi*(hi+1)/2 + lo
  always_comb begin
    if (is_sg) begin
      op_x = NW'(req.vertex_u);
      op_y = NW'(req.vertex_v);
    end else if (is_pair) begin
      op_x = ia;
      op_y = ib;
    end else begin
      op_x = ia;
      op_y = NW'(req.vertex_u);
    end
    hi = (op_x > op_y) ? op_x : op_y;
    lo = (op_x > op_y) ? op_y : op_x;
    tri_prod = PW'(hi) * (PW'(hi) + PW'(1));
    slot = AW'(tri_prod >> 1) + AW'(lo);
  end

  assign addr = cmd.clr_step ? clr_idx : slot;
  assign mem_we = cmd.clr_step | cmd.mem_wr;
  assign wdata = cmd.clr_step ? NO_EDGE_RESET : req.weight;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[addr];
    end
  end

  assign hit = rd_data != no_edge;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.req = req.req_type;
    stat.range_err = (is_sg && (u_big || v_big)) ||
                     (((req.req_type == REQ_NCOUNT) || (req.req_type == REQ_NLIST)) && u_big);
    stat.walk_done = (ia >= n_act) || (is_list && (k >= lim));
    stat.hit = hit;
    stat.pend_valid = pend_valid;
    stat.out_free = out_free;
    stat.clr_last = clr_idx == AW'(DEPTH - 1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      no_edge <= NO_EDGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[COUNT_W-1:0];
        CFG_NO_EDGE:      no_edge <= cfg_data;
      endcase
    end
  end

  // request, walk counters and the held list entry
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (cmd.load) begin
        pend_valid <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end
    end
    if (cmd.load) begin
      req <= in_item;
      lim <= (in_item.out_limit > RESULT_CAP) ? RESULT_CAP : in_item.out_limit;
      ia <= '0;
      ib <= '0;
      k <= '0;
      cnt <= '0;
    end else begin
      if (cmd.advance) begin
        if (is_pair) begin
          if ((ib + NW'(1)) < n_act) begin
            ib <= ib + NW'(1);
          end else begin
            ia <= ia + NW'(1);
            ib <= ia + NW'(1);
          end
        end else begin
          ia <= ia + NW'(1);
        end
      end
      if (cmd.cnt_inc && (cnt != '1)) begin
        cnt <= cnt + TALLY_W'(1);
      end
      if (cmd.pend_load) begin
        pend_u <= VERTEX_W'(ia);
        pend_v <= is_pair ? VERTEX_W'(ib) : req.vertex_u;
        pend_w <= rd_data;
        k <= k + LIMIT_W'(1);
      end
    end
  end

  always_comb begin
    out_next = '0;
    out_next.last = 1'b1;
    case (cmd.sel)
      OSEL_ERR: begin
        out_next.status = 1'b1;
      end
      OSEL_SET: begin
        out_next.found = req.weight != no_edge;
        out_next.result_u = req.vertex_u;
        out_next.result_v = req.vertex_v;
        out_next.result_weight = req.weight;
      end
      OSEL_GET: begin
        out_next.found = hit;
        out_next.result_u = req.vertex_u;
        out_next.result_v = req.vertex_v;
        out_next.result_weight = rd_data;
      end
      OSEL_COUNT: begin
        out_next.found = cnt != '0;
        out_next.result_u = req.vertex_u;
        out_next.tally = cnt;
      end
      OSEL_PEND, OSEL_FINAL: begin
        // an empty list leaves everything but last at zero
        if (pend_valid) begin
          out_next.found = 1'b1;
          out_next.result_u = pend_u;
          out_next.result_v = pend_v;
          out_next.result_weight = pend_w;
          out_next.tally = TALLY_W'(k);
        end
        out_next.last = cmd.sel == OSEL_FINAL;
      end
      default: begin
        out_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      out_item <= out_next;
    end
  end

endmodule

### src/tas_control.sv
module tas_control import tas_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  tas_stat_t stat,
  output tas_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SET,
    S_GET,
    S_ERR,
    S_WREAD,
    S_WCHECK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_list;

  assign is_list = (stat.req == REQ_NLIST) || (stat.req == REQ_ELIST);
  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.sel = OSEL_ERR;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.range_err) begin
          state_next = S_ERR;
        end else begin
          unique case (req_t'(stat.req)) inside
            REQ_SET: begin
              cmd.mem_wr = 1'b1;
              state_next = S_SET;
            end
            REQ_GET: begin
              cmd.mem_rd = 1'b1;
              state_next = S_GET;
            end
            REQ_NCOUNT, REQ_NLIST, REQ_ECOUNT, REQ_ELIST: begin
              state_next = S_WREAD;
            end
            default: begin
              // unknown request, no result
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SET: begin
        cmd.sel = OSEL_SET;
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_GET: begin
        cmd.sel = OSEL_GET;
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.sel = OSEL_ERR;
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WREAD: begin
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_WCHECK;
        end
      end
      S_WCHECK: begin
        cmd.sel = OSEL_PEND;
        if (!stat.hit) begin
          cmd.advance = 1'b1;
          state_next = S_WREAD;
        end else if (!is_list) begin
          cmd.cnt_inc = 1'b1;
          cmd.advance = 1'b1;
          state_next = S_WREAD;
        end else if (!stat.pend_valid || stat.out_free) begin
          // held entry goes out, the new hit takes its place
          cmd.push = stat.pend_valid;
          cmd.pend_load = 1'b1;
          cmd.advance = 1'b1;
          state_next = S_WREAD;
        end
      end
      S_FINISH: begin
        cmd.sel = is_list ? OSEL_FINAL : OSEL_COUNT;
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/triangular_adjacency_store_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+----------------------------
// input    | in_valid / in_stall  | in_item (in_item_t)
// output   | out_valid / out_stall| out_item (out_item_t)
// config   | cfg_we               | cfg_index, cfg_data
//
// set and get pass the decode state, then the set or get state loads the output register
// one request is worked at a time
// count and list requests walk the store slot by slot through one read port:
//   neighbour walks up to n slots, edge walks up to n*(n+1)/2, n = capped vertex count
// after reset a clearing pass writes the reset no-edge value to all
//   MAX_VERTICES*(MAX_VERTICES+1)/2 slots before input is taken
// results sit in an output register; a stalled output holds back the walk of a list
module triangular_adjacency_store_unit import tas_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data
);

  tas_cmd_t  cmd;
  tas_stat_t stat;

  tas_control u_control (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tas_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
